// ----- design/rnsd_pkg.sv -----
// Shared types and constants for the nibble-packed RLE sprite decoder.
// No dependencies; used by rnsd_parser and the core top level.
package rnsd_pkg;

  // Header info word fields.
  localparam logic [15:0] INFO_COMPRESSED = 16'h8000;
  localparam logic [15:0] INFO_MODE_A     = 16'h4000;
  localparam logic [15:0] INFO_MODE_B     = 16'h2000;
  localparam logic [15:0] INFO_WIDTH_MASK = 16'h01FF;
  localparam logic [15:0] WIDTH_ROUND     = 16'h03FC;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_INFO_HI = 8'b0000_0010,
    PH_HEIGHT  = 8'b0000_0100,
    PH_PAL     = 8'b0000_1000,
    PH_RAW     = 8'b0001_0000,
    PH_CTRL    = 8'b0010_0000,
    PH_FILL    = 8'b0100_0000,
    PH_LIT     = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAIR   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ERR_EMPTY_FRAME = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel_first;
    logic [7:0]  pixel_second;
    logic [7:0]  repeat_pairs;
    logic [9:0]  frame_width;
    logic [7:0]  frame_height;
    logic        frame_done;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ----- design/rnsd_parser.sv -----
// Header parser and pixel-run decoder: per-byte state and the result of each transfer that yields one.
// Depends on rnsd_pkg for phase codes and the result struct.
module rnsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             frame_start,
  output logic             res_fire,
  output rnsd_pkg::result_t res
);
  import rnsd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  info_low_byte, info_low_byte_next;
  logic [9:0]  width_px, width_px_next;
  logic [7:0]  height_rows, height_rows_next;
  logic [7:0]  pal_offset, pal_offset_next;
  logic        is_compressed, is_compressed_next;
  logic [15:0] pairs_left, pairs_left_next;
  logic [7:0]  run_left, run_left_next;

  logic [15:0] info;
  logic [15:0] width_round;
  logic [17:0] area;
  logic [7:0]  want;
  logic [7:0]  rep;
  logic [15:0] pairs_rem;
  logic        zero_keeps;
  logic [7:0]  pix_lo, pix_hi;
  logic [7:0]  run_dec;

  assign info        = {data_byte, info_low_byte};
  assign width_round = ((info & INFO_WIDTH_MASK) + 16'd3) & WIDTH_ROUND;
  assign area        = {8'b0, width_px} * {10'b0, height_rows};

  // Shared pair emission: clip the run to what is left of the frame.
  assign want       = (phase == PH_FILL) ? run_left : 8'd1;
  assign rep        = ({8'b0, want} > pairs_left) ? pairs_left[7:0] : want;
  assign pairs_rem  = pairs_left - {8'b0, rep};
  assign zero_keeps = (phase != PH_RAW);
  assign pix_lo     = (zero_keeps && data_byte[3:0] == 4'd0) ? 8'd0
                      : ({4'b0, data_byte[3:0]} + pal_offset);
  assign pix_hi     = (zero_keeps && data_byte[7:4] == 4'd0) ? 8'd0
                      : ({4'b0, data_byte[7:4]} + pal_offset);
  assign run_dec    = (run_left != 8'd0) ? (run_left - 8'd1) : 8'd0;

  always_comb begin
    phase_next         = phase;
    info_low_byte_next = info_low_byte;
    width_px_next      = width_px;
    height_rows_next   = height_rows;
    pal_offset_next    = pal_offset;
    is_compressed_next = is_compressed;
    pairs_left_next    = pairs_left;
    run_left_next      = run_left;
    res_fire           = 1'b0;
    res                = '0;
    if (take) begin
      if (frame_start) begin
        // Abandon any frame in flight.
        info_low_byte_next = data_byte;
        phase_next         = PH_INFO_HI;
      end else begin
        case (phase)
          PH_INFO_HI: begin
            if ((info & (INFO_MODE_A | INFO_MODE_B)) != 16'd0) begin
              res_fire       = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_UNSUPPORTED;
              phase_next     = PH_IDLE;
            end else begin
              is_compressed_next = (info & INFO_COMPRESSED) != 16'd0;
              width_px_next      = width_round[9:0];
              phase_next         = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            height_rows_next = data_byte;
            phase_next       = PH_PAL;
          end
          PH_PAL: begin
            pal_offset_next = data_byte;
            res_fire        = 1'b1;
            if (width_px == 10'd0 || height_rows == 8'd0) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_EMPTY_FRAME;
              phase_next     = PH_IDLE;
            end else begin
              pairs_left_next  = area[16:1];
              run_left_next    = 8'd0;
              phase_next       = is_compressed ? PH_CTRL : PH_RAW;
              res.kind         = KIND_HEADER;
              res.frame_width  = width_px;
              res.frame_height = height_rows;
            end
          end
          PH_CTRL: begin
            if (data_byte[7]) begin
              run_left_next = ~data_byte + 8'd2;
              phase_next    = PH_FILL;
            end else begin
              run_left_next = data_byte + 8'd1;
              phase_next    = PH_LIT;
            end
          end
          PH_RAW, PH_FILL, PH_LIT: begin
            if (phase == PH_FILL) begin
              run_left_next = 8'd0;
              phase_next    = PH_CTRL;
            end else if (phase == PH_LIT) begin
              run_left_next = run_dec;
              if (run_dec == 8'd0) begin
                phase_next = PH_CTRL;
              end
            end
            res_fire         = 1'b1;
            res.kind         = KIND_PAIR;
            res.pixel_first  = pix_lo;
            res.pixel_second = pix_hi;
            res.repeat_pairs = rep;
            res.frame_done   = (pairs_rem == 16'd0);
            pairs_left_next  = pairs_rem;
            if (pairs_rem == 16'd0) begin
              phase_next    = PH_IDLE;
              run_left_next = 8'd0;
            end
          end
          default: begin
            // Idle: drop the byte.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      info_low_byte <= '0;
      width_px      <= '0;
      height_rows   <= '0;
      pal_offset    <= '0;
      is_compressed <= 1'b0;
      pairs_left    <= '0;
      run_left      <= '0;
    end else begin
      phase         <= phase_next;
      info_low_byte <= info_low_byte_next;
      width_px      <= width_px_next;
      height_rows   <= height_rows_next;
      pal_offset    <= pal_offset_next;
      is_compressed <= is_compressed_next;
      pairs_left    <= pairs_left_next;
      run_left      <= run_left_next;
    end
  end

`ifndef SYNTHESIS
  a_run_phase_has_pairs: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RAW || phase == PH_FILL || phase == PH_LIT) |-> pairs_left != 16'd0)
    else $error("pixel phase with no pairs left");

  a_pair_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.kind == KIND_PAIR) |-> res.repeat_pairs != 8'd0)
    else $error("pixel run with zero repeat");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.frame_done) |=> phase == PH_IDLE)
    else $error("frame done but decoder not idle");
`endif

endmodule

// ----- design/rle_nibble_sprite_decoder_core.sv -----
// Top level of the nibble-packed RLE sprite decoder: byte channel in, result channel out.
// Depends on rnsd_pkg and rnsd_parser.
// Latency: a result is valid the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// Reset (rst, synchronous): decoder idle, waiting for a frame start; result register empty.
module rle_nibble_sprite_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  pixel_first,
  output logic [7:0]  pixel_second,
  output logic [7:0]  repeat_pairs,
  output logic [9:0]  frame_width,
  output logic [7:0]  frame_height,
  output logic        frame_done,
  output logic [1:0]  error_code
);
  import rnsd_pkg::*;

  logic    take;
  logic    step_fire;
  result_t step_res;
  result_t held;

  assign src_stall = res_valid && res_stall;
  assign take      = src_valid && !src_stall;

  rnsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .res_fire    (step_fire),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && step_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; load on a producing transfer.
  always_ff @(posedge clk) begin
    if (take && step_fire) begin
      held <= step_res;
    end
  end

  assign kind         = held.kind;
  assign pixel_first  = held.pixel_first;
  assign pixel_second = held.pixel_second;
  assign repeat_pairs = held.repeat_pairs;
  assign frame_width  = held.frame_width;
  assign frame_height = held.frame_height;
  assign frame_done   = held.frame_done;
  assign error_code   = held.error_code;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> res_valid)
    else $error("input stalled with empty result register");

  a_header_nonempty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KIND_HEADER) |-> (frame_width != 10'd0 && frame_height != 8'd0))
    else $error("header result with zero width or height");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KIND_ERROR) |-> error_code != ERR_NONE)
    else $error("error result without a code");
`endif

endmodule
